// ----- rtl/mceq_pkg.sv -----
package mceq_pkg;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_BAD_CH = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_EMPTY  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REC,
		ST_SCAN,
		ST_SETTLE,
		ST_POP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        cmd;
		logic [2:0]  channel;
		logic        edge_req;
		logic [31:0] timestamp;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] ev_timestamp;
		logic [15:0] ev_sequence;
		logic [2:0]  ev_channel;
		logic        ev_edge;
		logic [31:0] dropped_count;
		logic [6:0]  pending_total;
	} rsp_t;

	// one ring slot
	typedef struct packed {
		logic [31:0] ts;
		logic [15:0] seq;
		logic        edge_kind;
	} slot_t;

endpackage

// ----- rtl/mceq_if.sv -----
interface mceq_req_if;
	logic            valid;
	logic            ready;
	mceq_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mceq_rsp_if;
	logic            valid;
	logic            ready;
	mceq_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/multi_channel_event_queue_merge.sv -----
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    cmd, channel, edge_req, timestamp
// rsp      out  valid/ready    status, ev_*, dropped_count, pending_total
//
// A record runs ST_REC, ST_OUT; a pop ST_SCAN, ST_SETTLE, ST_POP, ST_OUT:
// the pop walks channel heads 1..CHANNELS-1 through one registered store read
// port and one 32-bit wrap-aware comparator, one head per cycle.
// One item at a time; req.ready is high only while idle.
// A held result does not stop the next req transfer; the block waits on rsp
// only when the next result is ready to go out.
// arst_n clears ring pointers, sequence and drop counters and the pending
// count; the event store needs no clearing.
module multi_channel_event_queue_merge #(
	parameter int CHANNELS    = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	mceq_req_if.sink    req,
	mceq_rsp_if.source  rsp
);

	localparam int CH_W = $clog2(CHANNELS);
	localparam int QD_W = $clog2(QUEUE_DEPTH);
	localparam int AW   = CH_W + QD_W;

	localparam logic [QD_W-1:0] PTR_LAST = QD_W'(QUEUE_DEPTH - 1);
	localparam logic [CH_W-1:0] CH_FIRST = CH_W'(1);
	localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNELS - 1);

	function automatic logic [QD_W-1:0] ring_next(input logic [QD_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + QD_W'(1);
	endfunction

	// sequencer
	mceq_pkg::state_t state_q, state_d;

	// captured item
	logic [2:0]  chan_q;
	logic        edge_q;
	logic [31:0] ts_q;

	// per-channel ring state
	logic [QD_W-1:0] wp_q   [CHANNELS];
	logic [QD_W-1:0] rp_q   [CHANNELS];
	logic [15:0]     seq_q  [CHANNELS];
	logic [31:0]     drop_q [CHANNELS];
	logic [6:0]      pend_q;

	// head scan
	logic [CH_W-1:0] scan_q;
	logic            cand_vld_s1;
	logic [CH_W-1:0] cand_ch_s1;

	// results
	mceq_pkg::rsp_t res_q, res_d;
	mceq_pkg::rsp_t out_q;
	logic           out_vld_q;

	// control
	logic accept, res_load, out_load, in_ready;

	// datapath
	logic [31:0]     ch_ext;
	logic            ch_ok;
	logic [CH_W-1:0] ch_idx;
	logic [CH_W-1:0] ptr_idx;
	logic [QD_W-1:0] wp_sel, rp_sel, nx_wp, nx_rp;
	logic            full;
	logic [31:0]     drop_sel, drop_inc;
	logic            nonempty;
	logic [31:0]     best_ext;

	logic            mem_we;
	mceq_pkg::slot_t mem_wdata, mem_rdata;

	logic            best_found;
	logic [CH_W-1:0] best_ch;
	mceq_pkg::slot_t best_slot;

	assign ch_ext = 32'(chan_q);
	assign ch_ok  = (ch_ext != 32'd0) && (ch_ext < 32'(CHANNELS));
	assign ch_idx = ch_ext[CH_W-1:0];

	// single pointer read port, steered by phase
	always_comb begin
		case (state_q)
			mceq_pkg::ST_SCAN: ptr_idx = scan_q;
			mceq_pkg::ST_POP:  ptr_idx = best_ch;
			default:           ptr_idx = ch_idx;
		endcase
	end

	assign wp_sel   = wp_q[ptr_idx];
	assign rp_sel   = rp_q[ptr_idx];
	assign nx_wp    = ring_next(wp_sel);
	assign nx_rp    = ring_next(rp_sel);
	assign full     = (nx_wp == rp_sel);
	assign nonempty = (wp_sel != rp_sel);
	assign drop_sel = drop_q[ch_idx];
	assign drop_inc = drop_sel + 32'd1;
	assign best_ext = 32'(best_ch);

	// next state and strobes
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		accept   = 1'b0;
		res_load = 1'b0;
		out_load = 1'b0;
		case (state_q)
			mceq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					accept  = 1'b1;
					state_d = (req.data.cmd == mceq_pkg::CMD_POP) ?
						mceq_pkg::ST_SCAN : mceq_pkg::ST_REC;
				end
			end
			mceq_pkg::ST_REC: begin
				res_load = 1'b1;
				state_d  = mceq_pkg::ST_OUT;
			end
			mceq_pkg::ST_SCAN: begin
				if (scan_q == CH_LAST) begin
					state_d = mceq_pkg::ST_SETTLE;
				end
			end
			mceq_pkg::ST_SETTLE: begin
				state_d = mceq_pkg::ST_POP;
			end
			mceq_pkg::ST_POP: begin
				res_load = 1'b1;
				state_d  = mceq_pkg::ST_OUT;
			end
			mceq_pkg::ST_OUT: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = mceq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mceq_pkg::ST_IDLE;
			end
		endcase
	end

	// result build
	always_comb begin
		res_d               = '0;
		res_d.dropped_count = ch_ok ? drop_sel : 32'd0;
		res_d.pending_total = pend_q;
		if (state_q == mceq_pkg::ST_REC) begin
			if (!ch_ok) begin
				res_d.status = mceq_pkg::STAT_BAD_CH;
			end else if (full) begin
				res_d.status        = mceq_pkg::STAT_FULL;
				res_d.dropped_count = drop_inc;
			end else begin
				res_d.status        = mceq_pkg::STAT_OK;
				res_d.pending_total = pend_q + 7'd1;
			end
		end else begin
			if (best_found) begin
				res_d.status        = mceq_pkg::STAT_OK;
				res_d.ev_timestamp  = best_slot.ts;
				res_d.ev_sequence   = best_slot.seq;
				res_d.ev_channel    = best_ext[2:0];
				res_d.ev_edge       = best_slot.edge_kind;
				res_d.pending_total = pend_q - 7'd1;
			end else begin
				res_d.status = mceq_pkg::STAT_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mceq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_q <= req.data.channel;
			edge_q <= req.data.edge_req;
			ts_q   <= req.data.timestamp;
		end
	end

	// ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]   <= '0;
				rp_q[i]   <= '0;
				seq_q[i]  <= '0;
				drop_q[i] <= '0;
			end
			pend_q <= '0;
		end else begin
			if (state_q == mceq_pkg::ST_REC && ch_ok) begin
				seq_q[ch_idx] <= seq_q[ch_idx] + 16'd1;
				if (full) begin
					drop_q[ch_idx] <= drop_inc;
				end else begin
					wp_q[ch_idx] <= nx_wp;
					pend_q       <= pend_q + 7'd1;
				end
			end
			if (state_q == mceq_pkg::ST_POP && best_found) begin
				rp_q[best_ch] <= nx_rp;
				pend_q        <= pend_q - 7'd1;
			end
		end
	end

	// scan walk: issue head read for scan_q, compare in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			cand_vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				scan_q <= CH_FIRST;
			end else if (state_q == mceq_pkg::ST_SCAN) begin
				scan_q <= scan_q + CH_W'(1);
			end
			cand_vld_s1 <= (state_q == mceq_pkg::ST_SCAN) && nonempty;
		end
	end

	always_ff @(posedge clk) begin
		cand_ch_s1 <= scan_q;
	end

	assign mem_we    = (state_q == mceq_pkg::ST_REC) && ch_ok && !full;
	assign mem_wdata = '{ts: ts_q, seq: seq_q[ch_idx], edge_kind: edge_q};

	mceq_store #(
		.ADDR_W (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr ({ch_idx, wp_sel}),
		.wdata (mem_wdata),
		.raddr ({scan_q, rp_sel}),
		.rdata (mem_rdata)
	);

	mceq_oldest #(
		.CH_W (CH_W)
	) u_oldest (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (accept),
		.cand_vld (cand_vld_s1),
		.cand_ch  (cand_ch_s1),
		.cand     (mem_rdata),
		.found    (best_found),
		.best_ch  (best_ch),
		.best     (best_slot)
	);

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign req.ready = in_ready;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

endmodule

// ----- rtl/mceq_store.sv -----
module mceq_store #(
	parameter int ADDR_W = 7
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  mceq_pkg::slot_t     wdata,
	input  logic [ADDR_W-1:0]   raddr,
	output mceq_pkg::slot_t     rdata
);

	mceq_pkg::slot_t mem_q [0:(1 << ADDR_W)-1];
	mceq_pkg::slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mceq_oldest.sv -----
module mceq_oldest #(
	parameter int CH_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              cand_vld,
	input  logic [CH_W-1:0]   cand_ch,
	input  mceq_pkg::slot_t   cand,
	output logic              found,
	output logic [CH_W-1:0]   best_ch,
	output mceq_pkg::slot_t   best
);

	logic              found_q;
	logic [CH_W-1:0]   best_ch_q;
	mceq_pkg::slot_t   best_q;
	logic [31:0]       diff;
	logic              take;

	// wrap-aware: candidate is older when (cand - best) is negative
	assign diff = cand.ts - best_q.ts;
	assign take = cand_vld && (!found_q || diff[31]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clr) begin
			best_ch_q <= cand_ch;
			best_q    <= cand;
		end
	end

	assign found   = found_q;
	assign best_ch = best_ch_q;
	assign best    = best_q;

endmodule

// ----- verif/mceq_tb_pkg.sv -----
package mceq_tb_pkg;

	import mceq_pkg::*;

	// Tracks the rings, sequence and drop counters the block should hold, and
	// the results it still owes.
	class event_merge_tracker;

		localparam int NCH   = 8;
		localparam int DEPTH = 16;

		int unsigned wr_idx[NCH];
		int unsigned rd_idx[NCH];
		logic [15:0] seq_next[NCH];
		logic [31:0] drops[NCH];
		slot_t       ring[NCH][DEPTH];
		rsp_t        awaited[$];
		int unsigned errors;
		int unsigned result_no;

		function new();
			for (int c = 0; c < NCH; c++) begin
				wr_idx[c]   = 0;
				rd_idx[c]   = 0;
				seq_next[c] = '0;
				drops[c]    = '0;
			end
			errors    = 0;
			result_no = 0;
		endfunction

		function bit chan_ok(logic [2:0] ch);
			return ch != 0 && int'(ch) < NCH;
		endfunction

		function int unsigned step_idx(int unsigned idx);
			return (idx + 1 >= DEPTH) ? 0 : idx + 1;
		endfunction

		// Applies one request to the tracked state and returns the result it gives.
		function rsp_t merge_outcome(req_t r);
			rsp_t        o;
			slot_t       s;
			int unsigned c;
			int unsigned nx;
			int unsigned pick;
			int unsigned total;
			bit          found;
			logic [31:0] best_ts;
			logic [31:0] diff;
			o       = '0;
			found   = 1'b0;
			pick    = 0;
			best_ts = '0;
			total   = 0;
			if (r.cmd == CMD_RECORD) begin
				if (!chan_ok(r.channel)) begin
					o.status = STAT_BAD_CH;
				end else begin
					c           = r.channel;
					nx          = step_idx(wr_idx[c]);
					s.ts        = r.timestamp;
					s.seq       = seq_next[c];
					s.edge_kind = r.edge_req;
					// sequence is consumed even if the ring is full
					seq_next[c] = seq_next[c] + 16'd1;
					if (nx == rd_idx[c]) begin
						drops[c] = drops[c] + 32'd1;
						o.status = STAT_FULL;
					end else begin
						ring[c][wr_idx[c]] = s;
						wr_idx[c]          = nx;
						o.status           = STAT_OK;
					end
				end
			end else begin
				for (c = 1; c < NCH; c++) begin
					if (rd_idx[c] != wr_idx[c]) begin
						diff = ring[c][rd_idx[c]].ts - best_ts;
						// strict: a tie keeps the lower channel
						if (!found || diff[31]) begin
							found   = 1'b1;
							pick    = c;
							best_ts = ring[c][rd_idx[c]].ts;
						end
					end
				end
				if (!found) begin
					o.status = STAT_EMPTY;
				end else begin
					s              = ring[pick][rd_idx[pick]];
					o.status       = STAT_OK;
					o.ev_timestamp = s.ts;
					o.ev_sequence  = s.seq;
					o.ev_channel   = pick[2:0];
					o.ev_edge      = s.edge_kind;
					rd_idx[pick]   = step_idx(rd_idx[pick]);
				end
			end
			o.dropped_count = chan_ok(r.channel) ? drops[r.channel] : 32'd0;
			for (c = 1; c < NCH; c++)
				total += (wr_idx[c] + DEPTH - rd_idx[c]) % DEPTH;
			o.pending_total = total[6:0];
			return o;
		endfunction

		function void note_request(req_t r);
			awaited.push_back(merge_outcome(r));
		endfunction

		function string show(rsp_t v);
			return $sformatf("st=%0d ts=%h seq=%h ch=%0d edge=%0d drop=%h pend=%0d",
				v.status, v.ev_timestamp, v.ev_sequence, v.ev_channel, v.ev_edge,
				v.dropped_count, v.pending_total);
		endfunction

		function void check_result(rsp_t got);
			rsp_t  exp;
			string bad;
			result_no++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d arrived with none awaited: %s", result_no, show(got));
				return;
			end
			exp = awaited.pop_front();
			bad = "";
			if (got.status !== exp.status)               bad = {bad, " status"};
			if (got.ev_timestamp !== exp.ev_timestamp)   bad = {bad, " ev_timestamp"};
			if (got.ev_sequence !== exp.ev_sequence)     bad = {bad, " ev_sequence"};
			if (got.ev_channel !== exp.ev_channel)       bad = {bad, " ev_channel"};
			if (got.ev_edge !== exp.ev_edge)             bad = {bad, " ev_edge"};
			if (got.dropped_count !== exp.dropped_count) bad = {bad, " dropped_count"};
			if (got.pending_total !== exp.pending_total) bad = {bad, " pending_total"};
			if (bad != "") begin
				errors++;
				if (errors <= 10) begin
					$display("result %0d wrong field(s):%s", result_no, bad);
					$display("  expected %s", show(exp));
					$display("  actual   %s", show(got));
				end
			end
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

	endclass

endpackage

// ----- verif/multi_channel_event_queue_merge_tb.sv -----
module multi_channel_event_queue_merge_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mceq_pkg::*;
	import mceq_tb_pkg::*;

	localparam int NUM_ITEMS   = 1500;
	// slowest item: a sender gap, a pop and a result stall; taken many times over
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;

	mceq_req_if req_ch ();
	mceq_rsp_if rsp_ch ();

	multi_channel_event_queue_merge #(
		.CHANNELS   (8),
		.QUEUE_DEPTH(16)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #1 clk = ~clk;

	event_merge_tracker tracker = new();

	int unsigned cycle_count = 0;
	int unsigned items_sent  = 0;
	// when set, the sender inserts no gaps for the current burst
	bit          send_steady = 1'b0;
	// running trigger time; starts just below the 32-bit wrap
	logic [31:0] time_base   = 32'hFFFF_F000;

	// Watchdog: a stuck handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: random stall per transfer, with stretches of none.
	initial begin
		int unsigned stall;
		int unsigned stretch;
		bit          steady;
		stretch = 0;
		steady  = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (stretch == 0) begin
				stretch = $urandom_range(1, 40);
				steady  = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			// ready sits high until the transfer happens
			do
				@(posedge clk);
			while (!rsp_ch.valid);
			tracker.check_result(rsp_ch.data);
		end
	end

	// One request transfer. valid is lowered only when a gap is drawn, so a
	// back-to-back item just swaps the payload.
	task automatic send_item(input logic cmd, input logic [2:0] ch, input logic edge_kind,
			input logic [31:0] stamp);
		req_t        r;
		int unsigned gap;
		r.cmd       = cmd;
		r.channel   = ch;
		r.edge_req  = edge_kind;
		r.timestamp = stamp;
		gap = send_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do
			@(posedge clk);
		while (!req_ch.ready);
		tracker.note_request(r);
		items_sent++;
	endtask

	// Hold off the sender until every awaited result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	// Mostly forward-moving time with small steps (so the wrap is crossed),
	// with repeats for ties and a few fully random stamps for far-apart heads.
	function automatic logic [31:0] next_stamp();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick < 2)
			return $urandom();
		if (pick < 4)
			return time_base;
		time_base = time_base + $urandom_range(0, 300);
		return time_base;
	endfunction

	initial begin
		int unsigned kind;
		int unsigned len;
		logic [2:0]  ch;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: invalid channel, empty pops, stamp extremes, wrap-aware
		// ordering and the lowest-channel tie break.
		send_item(CMD_RECORD, 3'd0, 1'b1, 32'hFFFF_FFFF);
		send_item(CMD_POP,    3'd0, 1'b0, 32'h0);
		send_item(CMD_POP,    3'd7, 1'b1, 32'h0);
		send_item(CMD_RECORD, 3'd1, 1'b1, 32'hFFFF_FFFF);
		send_item(CMD_RECORD, 3'd2, 1'b0, 32'h0000_0000);  // newer across the wrap
		send_item(CMD_RECORD, 3'd3, 1'b1, 32'hFFFF_FFFF);  // ties with channel 1
		send_item(CMD_RECORD, 3'd7, 1'b0, 32'h7FFF_FFFF);  // half-range apart: oldest
		send_item(CMD_POP,    3'd1, 1'b0, 32'h0);
		send_item(CMD_POP,    3'd0, 1'b0, 32'h0);
		send_item(CMD_POP,    3'd3, 1'b0, 32'h0);
		send_item(CMD_POP,    3'd2, 1'b0, 32'h0);
		send_item(CMD_POP,    3'd7, 1'b0, 32'h0);
		send_item(CMD_RECORD, 3'd5, 1'b1, 32'h8000_0000);
		send_item(CMD_RECORD, 3'd6, 1'b0, 32'h0000_0000);
		send_item(CMD_RECORD, 3'd4, 1'b1, 32'h5555_AAAA);
		send_item(CMD_POP,    3'd5, 1'b1, 32'hFFFF_FFFF);
		send_item(CMD_POP,    3'd6, 1'b0, 32'hAAAA_5555);
		send_item(CMD_POP,    3'd4, 1'b0, 32'h0);
		drain();

		// Random bursts: single-channel record runs fill rings and force drops,
		// pop runs empty them, mixed runs shuffle everything.
		while (items_sent < NUM_ITEMS) begin
			kind        = $urandom_range(0, 9);
			len         = $urandom_range(1, 18);
			send_steady = ($urandom_range(0, 3) == 0);
			if (kind < 4) begin
				ch = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
				                                 : 3'($urandom_range(1, 7));
				repeat (len)
					send_item(CMD_RECORD, ch, 1'($urandom_range(0, 1)), next_stamp());
			end else if (kind < 7) begin
				repeat (len)
					send_item(CMD_POP, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						$urandom());
			end else begin
				repeat (len)
					send_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
						1'($urandom_range(0, 1)), next_stamp());
			end
			// a full pause after any burst that ends partway through
			if (items_sent >= NUM_ITEMS / 2 && items_sent < NUM_ITEMS / 2 + 20)
				drain();
		end

		req_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		// room for a late stray result
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mceq_pkg.sv
rtl/mceq_if.sv
rtl/mceq_store.sv
rtl/mceq_oldest.sv
rtl/multi_channel_event_queue_merge.sv
verif/mceq_tb_pkg.sv
verif/multi_channel_event_queue_merge_tb.sv
